FILE: design/tvc_pkg.sv
// Shared types and constants for the token validator and classifier.
// Has no dependencies. All design files import it.
package tvc_pkg;

  // Transaction payloads.
  typedef struct packed {
    logic [7:0] token_byte;
    logic       last_byte;
  } tvc_in_t;

  typedef struct packed {
    logic [1:0]         token_class;
    logic signed [63:0] int_value;
  } tvc_out_t;

  typedef enum logic [1:0] {
    ClassInvalid = 2'd0,
    ClassInt     = 2'd1,
    ClassFloat   = 2'd2,
    ClassString  = 2'd3
  } tvc_class_e;

  typedef enum logic [3:0] {
    StStart   = 4'd0,
    StSign    = 4'd1,
    StInt     = 4'd2,
    StIntDot  = 4'd3,
    StDot     = 4'd4,
    StFrac    = 4'd5,
    StExp     = 4'd6,
    StExpSign = 4'd7,
    StExpDig  = 4'd8,
    StOther   = 4'd9
  } syn_state_e;

  // Next-state view of the number parser, as seen by the classifier.
  typedef struct packed {
    syn_state_e  state;
    logic        ovf;
    logic        neg;
    logic        mag_msb;
    logic [63:0] value;
  } syn_stat_t;

  // UTF-8 lead and continuation byte masks and marks.
  localparam logic [7:0] MaskCont  = 8'hC0;
  localparam logic [7:0] ContMark  = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Mark = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Mark = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Mark = 8'hF0;

  // Largest magnitude that can still take another decimal digit.
  localparam logic [63:0] MagDiv10 = 64'd922337203685477580;

endpackage

FILE: design/token_validate_classify.sv
// Top level of the token validator and classifier.
// Depends on tvc_pkg, tvc_utf8_check and tvc_num_parse.
//
// This block takes the bytes of one whitespace-free token, one byte per
// input transaction, with last_byte set on the final byte, and returns one
// output transaction per token: the class (rejected, integer, floating or
// plain string) and, for an integer, its signed 64-bit value (zero for every
// other class). A token is rejected for a stray ASCII control byte, a bad
// UTF-8 lead or continuation byte, or a character cut off at the token's
// end. Integers that do not fit 64 signed bits come back as floating. The
// block takes one byte per clock cycle, token after token, with no gaps
// while no final byte waits on an untaken result; the rate is set by the
// state update from the byte register, whose longest path is the decimal
// accumulate (multiply by ten as two shifted adds, plus the digit). A final
// byte passes the byte register and then the result register, from which
// the result is offered until it is taken. The result register frees the
// input side: bytes of the next token keep flowing while a result waits,
// and only a final byte stalls behind an untaken result.
module token_validate_classify
  import tvc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tvc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tvc_out_t out_data_o
);

  // Byte register.
  logic      in_valid_q;
  tvc_in_t   in_q;
  logic      adv;

  // Result register.
  logic      out_valid_q;
  tvc_out_t  out_q, out_d;

  logic      utf8_bad;
  syn_stat_t syn;

  // The held byte moves on unless it finishes a token and the result
  // register is still occupied by a result nobody has taken.
  assign adv        = in_valid_q &&
                      (!in_q.last_byte || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  tvc_utf8_check u_utf8 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (in_q.token_byte),
    .last_i (in_q.last_byte),
    .bad_o  (utf8_bad)
  );

  tvc_num_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (in_q.token_byte),
    .last_i (in_q.last_byte),
    .stat_o (syn)
  );

  // Classification from the state as it stands after the final byte. The
  // parser already tracks the negated magnitude, so the signed value is a
  // plain select. A positive magnitude with its top bit set is 2^63, which
  // only fits as a negative number.
  always_comb begin
    out_d.token_class = ClassString;
    out_d.int_value   = 64'sd0;
    if (utf8_bad) begin
      out_d.token_class = ClassInvalid;
    end else begin
      case (syn.state)
        StInt: begin
          if (syn.ovf || (!syn.neg && syn.mag_msb)) begin
            out_d.token_class = ClassFloat;
          end else begin
            out_d.token_class = ClassInt;
            out_d.int_value   = signed'(syn.value);
          end
        end
        StIntDot, StFrac, StExpDig: out_d.token_class = ClassFloat;
        default:                    out_d.token_class = ClassString;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_q.last_byte) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/tvc_utf8_check.sv
// UTF-8 and control-character checker with its per-token state.
// Depends on tvc_pkg.
module tvc_utf8_check
  import tvc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       bad_o
);

  logic [1:0] cont_q, cont_d;
  logic       inv_q, inv_d;

  always_comb begin
    cont_d = cont_q;
    inv_d  = inv_q;
    if (!inv_q) begin
      if (cont_q != 2'd0) begin
        if ((byte_i & MaskCont) != ContMark) begin
          inv_d = 1'b1;
        end else begin
          cont_d = cont_q - 2'd1;
        end
      end else if ((byte_i < 8'h20 && byte_i != 8'h09 && byte_i != 8'h0A &&
                    byte_i != 8'h0D) || byte_i == 8'h7F) begin
        inv_d = 1'b1;
      end else if (byte_i < 8'h80) begin
        cont_d = 2'd0;
      end else if ((byte_i & Lead2Mask) == Lead2Mark) begin
        cont_d = 2'd1;
      end else if ((byte_i & Lead3Mask) == Lead3Mark) begin
        cont_d = 2'd2;
      end else if ((byte_i & Lead4Mask) == Lead4Mark) begin
        cont_d = 2'd3;
      end else begin
        inv_d = 1'b1;
      end
    end
  end

  // A token is rejected on a fault or on a character left unfinished.
  assign bad_o = inv_d || (cont_d != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_q <= 2'd0;
      inv_q  <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        cont_q <= 2'd0;
        inv_q  <= 1'b0;
      end else begin
        cont_q <= cont_d;
        inv_q  <= inv_d;
      end
    end
  end

endmodule

FILE: design/tvc_num_parse.sv
// Number syntax state machine with the decimal accumulator.
// Depends on tvc_pkg.
module tvc_num_parse
  import tvc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output syn_stat_t  stat_o
);

  syn_state_e  state_q, state_d;
  logic [63:0] mag_q, mag_d;
  logic [63:0] nmag_q, nmag_d;   // two's complement negation of mag_q
  logic        ovf_q, ovf_d;
  logic        neg_q, neg_d;

  logic        is_digit, is_sign, is_dot, is_expo;
  logic [3:0]  digit;
  logic [63:0] mag_x10, nmag_x10;

  assign is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign is_sign  = (byte_i == 8'h2B) || (byte_i == 8'h2D);
  assign is_dot   = (byte_i == 8'h2E);
  assign is_expo  = (byte_i == 8'h65) || (byte_i == 8'h45);
  assign digit    = byte_i[3:0];

  assign mag_x10  = {mag_q[60:0], 3'b000} + {mag_q[62:0], 1'b0};
  assign nmag_x10 = {nmag_q[60:0], 3'b000} + {nmag_q[62:0], 1'b0};

  // Next state of the syntax machine.
  always_comb begin
    state_d = StOther;
    case (state_q)
      StStart: begin
        if (is_sign)       state_d = StSign;
        else if (is_digit) state_d = StInt;
        else if (is_dot)   state_d = StDot;
      end
      StSign: begin
        if (is_digit)    state_d = StInt;
        else if (is_dot) state_d = StDot;
      end
      StInt: begin
        if (is_digit)     state_d = StInt;
        else if (is_dot)  state_d = StIntDot;
        else if (is_expo) state_d = StExp;
      end
      StIntDot, StFrac: begin
        if (is_digit)     state_d = StFrac;
        else if (is_expo) state_d = StExp;
      end
      StDot: begin
        if (is_digit) state_d = StFrac;
      end
      StExp: begin
        if (is_sign)       state_d = StExpSign;
        else if (is_digit) state_d = StExpDig;
      end
      StExpSign, StExpDig: begin
        if (is_digit) state_d = StExpDig;
      end
      default: state_d = StOther;
    endcase
  end

  // Sign capture and digit accumulation.
  always_comb begin
    neg_d  = neg_q;
    mag_d  = mag_q;
    nmag_d = nmag_q;
    ovf_d  = ovf_q;
    if (state_q == StStart && is_sign) begin
      neg_d = (byte_i == 8'h2D);
    end
    if (state_d == StInt && !ovf_q) begin
      if (mag_q > MagDiv10 || (mag_q == MagDiv10 && digit > 4'd8)) begin
        ovf_d = 1'b1;
      end else begin
        mag_d  = mag_x10 + {60'd0, digit};
        nmag_d = nmag_x10 - {60'd0, digit};
      end
    end
  end

  assign stat_o.state   = state_d;
  assign stat_o.ovf     = ovf_d;
  assign stat_o.neg     = neg_d;
  assign stat_o.mag_msb = mag_d[63];
  assign stat_o.value   = neg_d ? nmag_d : mag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StStart;
      mag_q   <= 64'd0;
      nmag_q  <= 64'd0;
      ovf_q   <= 1'b0;
      neg_q   <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        state_q <= StStart;
        mag_q   <= 64'd0;
        nmag_q  <= 64'd0;
        ovf_q   <= 1'b0;
        neg_q   <= 1'b0;
      end else begin
        state_q <= state_d;
        mag_q   <= mag_d;
        nmag_q  <= nmag_d;
        ovf_q   <= ovf_d;
        neg_q   <= neg_d;
      end
    end
  end

endmodule

FILE: test/tb_token_validate_classify.sv
`timescale 1ns / 1ps
// Self-checking testbench for token_validate_classify: random and directed tokens,
// a byte-level classifier that predicts each result, and a result checker.
// Depends on tvc_pkg and the token_validate_classify design.
module tb_token_validate_classify;
  import tvc_pkg::*;

  // ASCII characters that matter to the UTF-8 check and the number syntax.
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDel   = 8'h7F;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpE   = 8'h45;
  localparam logic [7:0] ChLowE  = 8'h65;
  localparam logic [7:0] ChTilde = 8'h7E;

  localparam int unsigned TargetBytes = 1100;
  localparam int unsigned MaxIdle     = 2000;
  localparam int unsigned MaxReported = 10;

  typedef enum int unsigned {
    TokInt, TokEdge, TokFloat, TokText, TokBroken, TokNoise, TokMutant
  } tok_kind_e;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready_o;
  tvc_in_t  in_data = '0;
  logic     out_valid_o;
  logic     out_ready = 1'b0;
  tvc_out_t out_data_o;

  token_validate_classify DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Bytes waiting to be driven, and the token under construction.
  tvc_in_t    pending_bytes[$];
  logic [7:0] tok_bytes[$];

  // Results the classifier expects, oldest first.
  tvc_out_t awaited_results[$];

  // Classifier state for the token in flight; it mirrors the block's reset state.
  logic [1:0]  cont_left = '0;
  logic        bad_text  = 1'b0;
  syn_state_e  syn       = StStart;
  logic [63:0] mag       = '0;
  logic        mag_ovf   = 1'b0;
  logic        neg       = 1'b0;

  int unsigned fail_cnt = 0;

  // Steps the classifier by one accepted byte. On the final byte of a token it
  // queues the expected result and starts over for the next token.
  task automatic classify_byte(input tvc_in_t item);
    logic [7:0]  b;
    logic [63:0] dval;
    logic        dig, sgn, dot, expo;
    syn_state_e  nxt;
    tvc_out_t    res;
    b    = item.token_byte;
    dig  = (b >= ChZero) && (b <= ChNine);
    sgn  = (b == ChPlus) || (b == ChMinus);
    dot  = (b == ChDot);
    expo = (b == ChLowE) || (b == ChUpE);
    dval = 64'(b - ChZero);

    // UTF-8 check. A fault is sticky until the end of the token.
    if (!bad_text) begin
      if (cont_left != 2'd0) begin
        if ((b & MaskCont) != ContMark) bad_text = 1'b1;
        else cont_left = cont_left - 2'd1;
      end else if ((b < ChSpace && b != ChTab && b != ChLf && b != ChCr) || b == ChDel) begin
        bad_text = 1'b1;
      end else if (b < ContMark) begin
        // Plain ASCII character.
      end else if ((b & Lead2Mask) == Lead2Mark) begin
        cont_left = 2'd1;
      end else if ((b & Lead3Mask) == Lead3Mark) begin
        cont_left = 2'd2;
      end else if ((b & Lead4Mask) == Lead4Mark) begin
        cont_left = 2'd3;
      end else begin
        bad_text = 1'b1;
      end
    end

    // Number syntax. Anything that breaks the pattern falls into StOther for good.
    nxt = StOther;
    case (syn)
      StStart: begin
        if (sgn) begin
          nxt = StSign;
          neg = (b == ChMinus);
        end else if (dig) nxt = StInt;
        else if (dot) nxt = StDot;
      end
      StSign: begin
        if (dig) nxt = StInt;
        else if (dot) nxt = StDot;
      end
      StInt: begin
        if (dig) nxt = StInt;
        else if (dot) nxt = StIntDot;
        else if (expo) nxt = StExp;
      end
      StIntDot, StFrac: begin
        if (dig) nxt = StFrac;
        else if (expo) nxt = StExp;
      end
      StDot: begin
        if (dig) nxt = StFrac;
      end
      StExp: begin
        if (sgn) nxt = StExpSign;
        else if (dig) nxt = StExpDig;
      end
      StExpSign, StExpDig: begin
        if (dig) nxt = StExpDig;
      end
      default: ;
    endcase
    // The magnitude stops growing once one more digit could pass 2^63.
    if (nxt == StInt && !mag_ovf) begin
      if (mag > MagDiv10 || (mag == MagDiv10 && dval > 8)) mag_ovf = 1'b1;
      else mag = mag * 10 + dval;
    end
    syn = nxt;

    if (item.last_byte) begin
      res.int_value = '0;
      if (bad_text || cont_left != 2'd0) begin
        res.token_class = ClassInvalid;
      end else if (syn == StInt) begin
        // 2^63 fits only as a negative value.
        if (mag_ovf || (!neg && mag[63])) begin
          res.token_class = ClassFloat;
        end else begin
          res.token_class = ClassInt;
          res.int_value   = neg ? -mag : mag;
        end
      end else if (syn == StIntDot || syn == StFrac || syn == StExpDig) begin
        res.token_class = ClassFloat;
      end else begin
        res.token_class = ClassString;
      end
      awaited_results = {awaited_results, res};
      cont_left = '0;
      bad_text  = 1'b0;
      syn       = StStart;
      mag       = '0;
      mag_ovf   = 1'b0;
      neg       = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Token construction helpers.
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] v);
    tok_bytes = {tok_bytes, v};
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic put_digits(input int unsigned n);
    repeat (n) add_byte(ChZero + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_sign();
    case ($urandom_range(0, 2))
      0: add_byte(ChPlus);
      1: add_byte(ChMinus);
      default: ;
    endcase
  endtask

  task automatic put_cont(input int unsigned n);
    repeat (n) add_byte(ContMark | 8'($urandom_range(0, 63)));
  endtask

  // One well-formed character: mostly printable ASCII, some whitespace controls,
  // and multi-byte sequences of every length.
  task automatic put_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      add_byte(8'($urandom_range(ChSpace, ChTilde)));
    end else if (r < 60) begin
      add_byte(r < 57 ? ChTab : (r < 59 ? ChLf : ChCr));
    end else if (r < 75) begin
      add_byte(Lead2Mark | 8'($urandom_range(0, 31)));
      put_cont(1);
    end else if (r < 90) begin
      add_byte(Lead3Mark | 8'($urandom_range(0, 15)));
      put_cont(2);
    end else begin
      add_byte(Lead4Mark | 8'($urandom_range(0, 7)));
      put_cont(3);
    end
  endtask

  // Integer: mostly short, now and then long enough to overflow.
  task automatic put_integer();
    put_sign();
    if ($urandom_range(0, 9) == 0) put_digits($urandom_range(15, 22));
    else put_digits($urandom_range(1, 6));
  endtask

  // Decimal and exponent forms, with the odd incomplete one.
  task automatic put_float();
    put_sign();
    case ($urandom_range(0, 2))
      0: begin
        put_digits($urandom_range(1, 4));
        add_byte(ChDot);
        put_digits($urandom_range(0, 4));
      end
      1: begin
        put_digits($urandom_range(0, 3));
        add_byte(ChDot);
        put_digits($urandom_range(1, 4));
      end
      default: put_digits($urandom_range(1, 4));
    endcase
    if ($urandom_range(0, 2) != 0) begin
      add_byte($urandom_range(0, 1) ? ChLowE : ChUpE);
      put_sign();
      put_digits($urandom_range(0, 3));
    end
  endtask

  // Moves the built token into the send queue, flagging its final byte.
  task automatic send_token();
    tvc_in_t item;
    foreach (tok_bytes[i]) begin
      item.token_byte = tok_bytes[i];
      item.last_byte  = (i == tok_bytes.size() - 1);
      pending_bytes = {pending_bytes, item};
    end
    tok_bytes.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r;
    int unsigned lead_len;
    logic [7:0]  b;
    tok_kind_e   kind;

    // Directed tokens: byte extremes, every class, and each corner of the check.
    add_byte(8'h00); send_token();                     // control byte
    add_byte(8'hFF); send_token();                     // never a lead byte
    put_text("7"); send_token();                       // single-digit integer
    put_text("-"); send_token();                       // sign alone is a string
    put_text("1.e5"); send_token();                    // exponent after a bare dot
    put_text(".5"); send_token();                      // fraction with no integer part
    put_text("1e+"); send_token();                     // exponent with no digits
    add_byte(8'hC3); send_token();                     // character cut off at the end
    add_byte(8'hC3); add_byte(8'hA9); send_token();
    add_byte(ContMark); put_text("1"); send_token();   // fault, then a digit
    put_text("+."); send_token();
    add_byte(ChTab); send_token();
    add_byte(8'hF0); add_byte(8'h9F);
    add_byte(8'h98); add_byte(8'h80); send_token();

    // Random tokens, mostly well formed, the rest noise and broken text.
    while (pending_bytes.size() < TargetBytes) begin
      r = $urandom_range(0, 99);
      kind = r < 22 ? TokInt : r < 30 ? TokEdge : r < 50 ? TokFloat :
             r < 65 ? TokText : r < 77 ? TokBroken : r < 85 ? TokNoise : TokMutant;
      case (kind)
        TokInt:   put_integer();
        TokFloat: put_float();
        TokEdge: begin
          // Values around the 64-bit signed limits, plus leading zeros and minus zero.
          case ($urandom_range(0, 9))
            0: put_text("9223372036854775807");
            1: put_text("-9223372036854775808");
            2: put_text("18446744073709551616");
            3: put_text("00000000000000000000000123");
            4: put_text("-0");
            default: begin
              put_sign();
              put_text("922337203685477580");
              put_digits($urandom_range(1, 2));
            end
          endcase
        end
        TokText: begin
          repeat ($urandom_range(1, 6)) put_char();
        end
        TokBroken: begin
          repeat ($urandom_range(0, 3)) put_char();
          lead_len = $urandom_range(2, 4);
          b = lead_len == 2 ? Lead2Mark : (lead_len == 3 ? Lead3Mark : Lead4Mark);
          case ($urandom_range(0, 4))
            0: begin
              // The token ends before the character is complete.
              add_byte(b);
              put_cont($urandom_range(0, lead_len - 2));
            end
            1: begin
              // A lead byte followed by something that is not a continuation.
              add_byte(b);
              b = 8'($urandom);
              if ((b & MaskCont) == ContMark) b = b ^ 8'h40;
              add_byte(b);
            end
            2: add_byte(ContMark | 8'($urandom_range(0, 63)));
            3: begin
              b = 8'($urandom_range(0, 32));
              if (b == ChSpace) b = ChDel;
              else if (b == ChTab || b == ChLf || b == ChCr) b = 8'h00;
              add_byte(b);
            end
            default: add_byte(8'($urandom_range(8'hF8, 8'hFF)));
          endcase
          if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 3)) put_char();
        end
        TokNoise: begin
          repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
        end
        default: begin
          // A number with one printable character swapped in at random.
          if ($urandom_range(0, 1) == 1) put_integer();
          else put_float();
          tok_bytes[$urandom_range(0, tok_bytes.size() - 1)] =
              8'($urandom_range(ChSpace, ChTilde));
        end
      endcase
      send_token();
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every byte sent and every result back, then a few quiet cycles to
    // catch anything extra.
    @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: presents one byte at a time and holds it until the transaction
  // completes. Gaps are drawn at random per byte, with calm stretches where
  // the bytes go back to back.
  // ---------------------------------------------------------------------------
  int unsigned in_wait = 0;
  logic        in_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_wait = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        classify_byte(in_data);
        if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
        in_wait = in_calm ? 0 : $urandom_range(0, 9);
      end
      if (!in_valid || in_ready_o) begin
        if (in_wait != 0) begin
          in_wait = in_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest expectation and
  // stalls the result side at random after each one.
  // ---------------------------------------------------------------------------
  int unsigned out_wait = 0;
  logic        out_calm = 1'b0;
  tvc_out_t    got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        got = out_data_o;
        if (awaited_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MaxReported)
            $display("unexpected result: class %0d value %0d",
                     got.token_class, $signed(got.int_value));
        end else begin
          want = awaited_results.pop_front();
          if (got.token_class !== want.token_class || got.int_value !== want.int_value) begin
            fail_cnt++;
            if (fail_cnt <= MaxReported)
              $display("result mismatch: class %0d value %0d, expected class %0d value %0d",
                       got.token_class, $signed(got.int_value),
                       want.token_class, $signed(want.int_value));
          end
        end
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
        out_wait = out_calm ? 0 : $urandom_range(0, 9);
      end
      if (out_wait != 0) begin
        out_wait = out_wait - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction on either side means
  // the block has hung.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= MaxIdle) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
